>>> hdl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and character helpers for the radix string converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int RSC_VALUE_BITS  = 31;
    localparam int RSC_STACK_DEPTH = 32;
    localparam int RSC_QUEUE_DEPTH = 2;

    localparam logic [5:0] RSC_BASE_MIN   = 6'd2;
    localparam logic [5:0] RSC_BASE_MAX   = 6'd36;
    localparam logic [5:0] RSC_BASE_RESET = 6'd10;
    localparam logic [5:0] RSC_NO_DIGIT   = 6'd36;
    localparam logic [6:0] RSC_ERR_CHAR   = 7'h30;

    localparam logic REG_IN_BASE  = 1'b0;
    localparam logic REG_OUT_BASE = 1'b1;

    // One classified input character as it travels through the queue.
    typedef struct packed {
        logic       drop;
        logic [5:0] digit;
        logic       last;
    } rsc_item_t;

    function automatic logic [5:0] clamp_base(input logic [5:0] b);
        logic [5:0] r;
        r = b;
        if (b < RSC_BASE_MIN) r = RSC_BASE_MIN;
        if (b > RSC_BASE_MAX) r = RSC_BASE_MAX;
        return r;
    endfunction

    function automatic logic is_dropped(input logic [7:0] c);
        logic r;
        case (c)
            8'h21, 8'h22, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2C, 8'h2D, 8'h2E, 8'h3C, 8'h3F, 8'h5C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Digit value 0..35, or RSC_NO_DIGIT for anything that is not a digit.
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] u;
        logic [5:0] r;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A) u = c - 8'd32;
        r = RSC_NO_DIGIT;
        if (u >= 8'h30 && u <= 8'h39) r = 6'(u - 8'h30);
        if (u >= 8'h41 && u <= 8'h5A) r = 6'(u - 8'h41 + 8'd10);
        return r;
    endfunction

    function automatic logic [6:0] to_ascii(input logic [5:0] d);
        logic [6:0] r;
        if (d < 6'd10) r = 7'h30 + {1'b0, d};
        else r = 7'h41 + {1'b0, d} - 7'd10;
        return r;
    endfunction

endpackage

>>> hdl/radix_string_converter.sv
// ----------------------------------------------------------------------------
// radix_string_converter
// Converts an ASCII numeral from one radix (2 to 36) to another.
// A character is taken at a rising edge with start high and busy low; last_in
// marks the end of the numeral. Some punctuation is dropped, letters fold to
// upper case. Results appear for one cycle each with result_strobe high, most
// significant digit first, last_out on the final digit; a bad digit, overflow
// or an empty numeral gives one transaction with error set instead.
// Bases must be written through wr_en/wr_index/wr_data while the block is
// idle; the block does not enforce this. A two-entry queue parts the input
// from the converter. A character that does not end the numeral is folded
// into the value. After the last one, the output digits are found by
// bit-serial division, pushed on the digit stack and read back from it; no
// new character is popped until the numeral is done, and busy holds input off
// once the queue is full. The receiver cannot stall. Reset sets both bases to
// 10 and clears the numeral; the digit stack needs no clearing.
// ----------------------------------------------------------------------------
module radix_string_converter
    import rsc_pkg::*;
#(
    parameter int VALUE_BITS  = RSC_VALUE_BITS,
    parameter int STACK_DEPTH = RSC_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] char_in,
    input  logic       last_in,
    input  logic       wr_en,
    input  logic       wr_index,
    input  logic [5:0] wr_data,
    output logic       result_strobe,
    output logic [6:0] digit_char,
    output logic       last_out,
    output logic       error
);

    logic [5:0] in_base_reg;
    logic [5:0] out_base_reg;
    logic       item_valid;
    rsc_item_t  item;
    logic       item_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_base_reg  <= RSC_BASE_RESET;
            out_base_reg <= RSC_BASE_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_IN_BASE) in_base_reg <= wr_data;
            if (wr_index == REG_OUT_BASE) out_base_reg <= wr_data;
        end
    end

    rsc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .char_in    (char_in),
        .last_in    (last_in),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    rsc_back
    #(
        .VALUE_BITS  (VALUE_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_base       (in_base_reg),
        .out_base      (out_base_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .result_strobe (result_strobe),
        .digit_char    (digit_char),
        .last_out      (last_out),
        .error         (error)
    );

`ifndef SYNTH
    // An error transaction always closes the numeral and carries '0'.
    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && error |-> last_out && digit_char == RSC_ERR_CHAR)
        else $error("error result without last_out or with a digit");

    // Every emitted character is a legal digit character.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (digit_char >= 7'h30 && digit_char <= 7'h39) ||
                          (digit_char >= 7'h41 && digit_char <= 7'h5A))
        else $error("emitted character is not a digit");

    // The converter never pops an empty queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid)
        else $error("queue popped while empty");
`endif

endmodule

>>> hdl/rsc_front.sv
// ----------------------------------------------------------------------------
// rsc_front
// Accepts characters, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module rsc_front
    import rsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] char_in,
    input  logic       last_in,
    output logic       item_valid,
    output rsc_item_t  item,
    input  logic       item_pop
);

    localparam int PTR_W = (RSC_QUEUE_DEPTH > 1) ? $clog2(RSC_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(RSC_QUEUE_DEPTH + 1);

    rsc_item_t        queue_reg [RSC_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;
    rsc_item_t        new_item;

    assign busy       = (count_reg == CNT_W'(RSC_QUEUE_DEPTH));
    assign push       = start && !busy;
    assign item_valid = (count_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.drop  = is_dropped(char_in);
        new_item.digit = digit_value(char_in);
        new_item.last  = last_in;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RSC_QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RSC_QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) queue_reg[wr_ptr_reg] <= new_item;
    end

endmodule

>>> hdl/rsc_back.sv
// ----------------------------------------------------------------------------
// rsc_back
// Accumulates digits, converts the value by serial division and emits digits.
// ----------------------------------------------------------------------------
module rsc_back
    import rsc_pkg::*;
#(
    parameter int VALUE_BITS  = RSC_VALUE_BITS,
    parameter int STACK_DEPTH = RSC_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [5:0] in_base,
    input  logic [5:0] out_base,
    input  logic       item_valid,
    input  rsc_item_t  item,
    output logic       item_pop,
    output logic       result_strobe,
    output logic [6:0] digit_char,
    output logic       last_out,
    output logic       error
);

    localparam int PROD_W = VALUE_BITS + 7;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int BIT_W  = $clog2(VALUE_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    logic                  err_reg;
    logic                  err_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [VALUE_BITS-1:0] quo_next;
    logic [5:0]            rem_reg;
    logic [5:0]            rem_next;
    logic [BIT_W-1:0]      bit_reg;
    logic [BIT_W-1:0]      bit_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [5:0]            rd_data_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [6:0]            out_char_reg;
    logic [6:0]            out_char_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  out_err_reg;
    logic                  out_err_next;

    logic [5:0]            stack_mem [STACK_DEPTH];
    logic                  mem_we;
    logic [CNT_W-1:0]      cnt_minus;
    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      wr_idx;

    logic [5:0]            ib;
    logic [5:0]            ob;
    logic [PROD_W-1:0]     prod;
    logic                  ovf;
    logic [6:0]            trial;
    logic                  take;
    logic [5:0]            rem_step;
    logic [VALUE_BITS-1:0] quo_step;

    assign ib        = clamp_base(in_base);
    assign ob        = clamp_base(out_base);
    assign prod      = PROD_W'(acc_reg) * PROD_W'(ib) + PROD_W'(item.digit);
    assign ovf       = |prod[PROD_W-1:VALUE_BITS];
    assign cnt_minus = cnt_reg - 1'b1;
    assign rd_idx    = cnt_minus[IDX_W-1:0];
    assign wr_idx    = cnt_reg[IDX_W-1:0];

    // One restoring division step: the quotient bit shifts in where the
    // dividend bit shifts out.
    assign trial    = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign take     = (trial >= {1'b0, ob});
    assign rem_step = take ? 6'(trial - {1'b0, ob}) : trial[5:0];
    assign quo_step = {quo_reg[VALUE_BITS-2:0], take};

    always_comb
    begin
        logic [VALUE_BITS-1:0] acc_v;
        logic                  err_v;
        logic                  seen_v;

        state_next     = state_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        seen_next      = seen_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        out_valid_next = 1'b0;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        item_pop       = 1'b0;
        mem_we         = 1'b0;
        acc_v          = acc_reg;
        err_v          = err_reg;
        seen_v         = seen_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    if (!item.drop && !err_reg)
                    begin
                        if (item.digit >= ib) err_v = 1'b1;
                        else if (ovf) err_v = 1'b1;
                        else
                        begin
                            acc_v  = prod[VALUE_BITS-1:0];
                            seen_v = 1'b1;
                        end
                    end
                    if (item.last)
                    begin
                        acc_next  = '0;
                        err_next  = 1'b0;
                        seen_next = 1'b0;
                        if (err_v || !seen_v)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = RSC_ERR_CHAR;
                            out_last_next  = 1'b1;
                            out_err_next   = 1'b1;
                        end
                        else
                        begin
                            quo_next   = acc_v;
                            rem_next   = '0;
                            bit_next   = BIT_W'(VALUE_BITS - 1);
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        acc_next  = acc_v;
                        err_next  = err_v;
                        seen_next = seen_v;
                    end
                end
            end
            ST_DIV:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    if (cnt_reg == CNT_W'(STACK_DEPTH))
                    begin
                        // The value needs more digits than the stack holds.
                        out_valid_next = 1'b1;
                        out_char_next  = RSC_ERR_CHAR;
                        out_last_next  = 1'b1;
                        out_err_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (quo_step == '0) state_next = ST_POP;
                        else
                        begin
                            rem_next = '0;
                            bit_next = BIT_W'(VALUE_BITS - 1);
                        end
                    end
                end
            end
            ST_POP:
            begin
                cnt_next   = cnt_minus;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid_next = 1'b1;
                out_char_next  = to_ascii(rd_data_reg);
                out_last_next  = (cnt_reg == '0);
                out_err_next   = 1'b0;
                state_next     = (cnt_reg == '0) ? ST_IDLE : ST_POP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            err_reg       <= err_next;
            seen_reg      <= seen_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) stack_mem[wr_idx] <= rem_step;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_POP) rd_data_reg <= stack_mem[rd_idx];
    end

    assign result_strobe = out_valid_reg;
    assign digit_char    = out_char_reg;
    assign last_out      = out_last_reg;
    assign error         = out_err_reg;

endmodule
